FILE: hw/rtl/clut_pkg.sv
// Shared types, constants and colour helpers for the CLUT texel expander.
package clut_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = 8;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int NUM_LANES     = 4;
  localparam int COUNT_W       = 3;
  localparam int PIXEL_W       = 32;
  localparam int S_TDATA_W     = 48;
  localparam int CFG_DATA_W    = 2;

  localparam logic [IDX_W:0]   PAL_LIMIT    = (IDX_W + 1)'(PALETTE_DEPTH);
  localparam logic [PIXEL_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_CONVERT   = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    DEPTH_4BIT   = 2'd0,
    DEPTH_8BIT   = 2'd1,
    DEPTH_DIRECT = 2'd2,
    DEPTH_NONE   = 2'd3
  } depth_mode_t;

  typedef enum logic {
    CFG_DEPTH_MODE      = 1'b0,
    CFG_PALETTE_PRESENT = 1'b1
  } cfg_reg_t;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [15:0]       data;
  } pal_wr_t;

  typedef struct packed {
    depth_mode_t mode;
    logic        present;
    logic [15:0] word;
  } lane_ctl_t;

  // floor(v * 255 / 31) for every 5-bit channel value
  localparam logic [7:0] WIDEN5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic pixel_t pack_color(input logic [15:0] c, input logic transparent);
    logic [7:0] a;
    a = transparent ? 8'h00 : 8'hFF;
    return {a, WIDEN5_LUT[c[14:10]], WIDEN5_LUT[c[9:5]], WIDEN5_LUT[c[4:0]]};
  endfunction

endpackage

FILE: hw/rtl/clut_lane.sv
// One texel lane: private palette copy, registered read and colour expansion.
module clut_lane (
  input  logic                      clk,
  input  clut_pkg::pal_wr_t         wr,
  input  logic                      rd_en,
  input  logic [clut_pkg::IDX_W-1:0] rd_idx,
  input  clut_pkg::lane_ctl_t       ctl,
  output clut_pkg::pixel_t          pixel
);

  logic [15:0]                 mem [clut_pkg::PALETTE_DEPTH];
  logic [15:0]                 rd_data;
  logic [clut_pkg::IDX_W-1:0]  idx;
  logic                        in_range;
  logic [15:0]                 color;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx[clut_pkg::PAL_AW-1:0]];
      idx     <= rd_idx;
    end
  end

  assign in_range = ({1'b0, idx} < clut_pkg::PAL_LIMIT);

  always_comb begin
    color = in_range ? rd_data : 16'h0000;
    case (ctl.mode)
      clut_pkg::DEPTH_4BIT, clut_pkg::DEPTH_8BIT: begin
        pixel = ctl.present ? clut_pkg::pack_color(color, idx == '0)
                            : clut_pkg::OPAQUE_BLACK;
      end
      clut_pkg::DEPTH_DIRECT: begin
        pixel = clut_pkg::pack_color(ctl.word, ctl.word == 16'h0000);
      end
      default: begin
        pixel = clut_pkg::OPAQUE_BLACK;
      end
    endcase
  end

endmodule

FILE: hw/rtl/clut_merge.sv
// Merge stage: takes the lanes' texels of one word and sends them out one per cycle while m_tready is high.
module clut_merge (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic [clut_pkg::COUNT_W-1:0]                      in_count,
  input  clut_pkg::pixel_t [clut_pkg::NUM_LANES-1:0]        in_pixels,
  output logic                                              load,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  output logic [clut_pkg::PIXEL_W-1:0]                      m_tdata,   // pixel_rgba
  output logic                                              m_tlast    // last_of_word
);

  localparam int PTR_W = $clog2(clut_pkg::NUM_LANES);

  clut_pkg::pixel_t [clut_pkg::NUM_LANES-1:0] pixels;
  logic [clut_pkg::COUNT_W-1:0]               count;
  logic [PTR_W-1:0]                           ptr;
  logic                                       busy;
  logic                                       last;
  logic                                       out_accept;

  assign last       = ({{(clut_pkg::COUNT_W - PTR_W){1'b0}}, ptr} == count - 1'b1);
  assign out_accept = busy & m_tready;
  assign load       = in_valid & (~busy | (out_accept & last));

  assign m_tvalid = busy;
  assign m_tdata  = pixels[ptr];
  assign m_tlast  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      ptr  <= '0;
    end else if (out_accept) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixels <= in_pixels;
      count  <= in_count;
    end
  end

endmodule

FILE: hw/rtl/clut_texel_to_rgba_converter_unit.sv
// Top level of the CLUT texel expander: config, item decode, lanes and merge stage.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tdata (index, colour, word, count),
//           |           |                      | s_tuser (command)
//  m_       | out       | m_tvalid / m_tready  | m_tdata (pixel_rgba), m_tlast
//  cfg_     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A word with n texels (after clamping) yields n output texels; palette writes and
// words with a clamped count of zero yield none.
// The first texel is valid once the item has passed the palette read and then the merge
// load, which waits while the merge stage still drains the previous word.
// The merge buffer parts the sides: the next item is taken while texels still drain.
// rst clears control state and the config registers; palette copies are not cleared.
// cfg_ready is always high.
module clut_texel_to_rgba_converter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] palette_index, [23:8] palette_color, [39:24] source_word,
  // [42:40] texel_count, [47:43] zero
  input  logic [clut_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,   // [0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [clut_pkg::PIXEL_W-1:0]        m_tdata,   // [31:0] pixel_rgba
  output logic                                m_tlast,   // last_of_word
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [clut_pkg::CFG_DATA_W-1:0]     cfg_data
);

  clut_pkg::depth_mode_t depth_mode;
  logic                  palette_present;

  logic                            s_accept;
  logic [clut_pkg::IDX_W-1:0]      in_pidx;
  logic [15:0]                     in_pcol;
  logic [15:0]                     in_word;
  logic [clut_pkg::COUNT_W-1:0]    in_count;
  logic [clut_pkg::COUNT_W-1:0]    max_count;
  logic [clut_pkg::COUNT_W-1:0]    clamped;
  logic                            is_convert;

  logic                            s1_valid;
  logic [clut_pkg::COUNT_W-1:0]    s1_count;
  clut_pkg::lane_ctl_t             s1_ctl;

  clut_pkg::pal_wr_t               pal_wr;
  logic                            rd_en;
  logic [clut_pkg::IDX_W-1:0]      lane_idx [clut_pkg::NUM_LANES];
  clut_pkg::pixel_t [clut_pkg::NUM_LANES-1:0] lane_pixels;
  logic                            load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode      <= clut_pkg::DEPTH_DIRECT;
      palette_present <= 1'b1;
    end else if (cfg_valid) begin
      case (clut_pkg::cfg_reg_t'(cfg_index))
        clut_pkg::CFG_DEPTH_MODE:      depth_mode      <= clut_pkg::depth_mode_t'(cfg_data[1:0]);
        clut_pkg::CFG_PALETTE_PRESENT: palette_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_pidx  = s_tdata[7:0];
  assign in_pcol  = s_tdata[23:8];
  assign in_word  = s_tdata[39:24];
  assign in_count = s_tdata[42:40];

  assign is_convert = (clut_pkg::command_t'(s_tuser) == clut_pkg::CMD_CONVERT);
  assign s_tready   = ~s1_valid | load;
  assign s_accept   = s_tvalid & s_tready;

  always_comb begin
    case (depth_mode)
      clut_pkg::DEPTH_4BIT: max_count = 3'd4;
      clut_pkg::DEPTH_8BIT: max_count = 3'd2;
      default:              max_count = 3'd1;
    endcase
    clamped = (in_count > max_count) ? max_count : in_count;
  end

  always_comb begin
    pal_wr.en   = s_accept & ~is_convert & ({1'b0, in_pidx} < clut_pkg::PAL_LIMIT);
    pal_wr.addr = in_pidx[clut_pkg::PAL_AW-1:0];
    pal_wr.data = in_pcol;
  end

  assign rd_en = s_accept & is_convert;

  // texel k of the word: nibble k, or byte k in 8-bit mode
  for (genvar k = 0; k < clut_pkg::NUM_LANES; k++) begin : g_idx
    if (k < 2) begin : g_byte
      assign lane_idx[k] = (depth_mode == clut_pkg::DEPTH_4BIT)
                           ? {4'h0, in_word[4*k +: 4]} : in_word[8*k +: 8];
    end else begin : g_nib
      assign lane_idx[k] = {4'h0, in_word[4*k +: 4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= is_convert & (clamped != '0);
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_count        <= clamped;
      s1_ctl.mode     <= depth_mode;
      s1_ctl.present  <= palette_present;
      s1_ctl.word     <= in_word;
    end
  end

  for (genvar k = 0; k < clut_pkg::NUM_LANES; k++) begin : g_lane
    clut_lane u_lane (
      .clk    (clk),
      .wr     (pal_wr),
      .rd_en  (rd_en),
      .rd_idx (lane_idx[k]),
      .ctl    (s1_ctl),
      .pixel  (lane_pixels[k])
    );
  end

  clut_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_count  (s1_count),
    .in_pixels (lane_pixels),
    .load      (load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: hw/rtl/clut_checker.sv
// Port-level checks for the CLUT texel expander, bound to the top level.
module clut_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [clut_pkg::PIXEL_W-1:0]    m_tdata,
  input logic                            m_tlast
);

  logic s_acc;
  assign s_acc = s_tvalid & s_tready;

  // a stalled texel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output texel changed while stalled");

  // with the output empty the input side is never blocked
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output idle");

  // no texel appears without an item taken shortly before
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (!s_acc && !m_tvalid) ##1 (!s_acc && !m_tvalid) |=> !m_tvalid)
    else $error("texel produced with no item pending");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind clut_texel_to_rgba_converter_unit clut_checker u_checker (.*);

FILE: tb/clut_texel_to_rgba_converter_unit_test.sv
// Self-checking testbench for the CLUT texel expander: directed, then random items.
`timescale 1ns / 1ps

module clut_texel_to_rgba_converter_unit_test;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    clut_pkg::command_t cmd;
    logic [7:0]         pal_idx;
    logic [15:0]        pal_color;
    logic [15:0]        word;
    logic [2:0]         count;
  } tex_item_t;

  typedef struct {
    clut_pkg::cfg_reg_t sel;
    logic [1:0]         val;
  } cfg_write_t;

  typedef struct {
    clut_pkg::pixel_t rgba;
    logic             last;
  } texel_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [clut_pkg::S_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [clut_pkg::PIXEL_W-1:0]    m_tdata;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = 1'b0;
  logic [clut_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tex_item_t   item_q[$];
  cfg_write_t  cfg_q[$];
  texel_t      texel_q[$];

  // Palette as the block should hold it, plus the settings in force
  logic [15:0]            palette_sh [clut_pkg::PALETTE_DEPTH];
  clut_pkg::depth_mode_t  depth_sh;
  logic                   present_sh;

  // Entries written so far, so that indexed words only name loaded entries
  bit           pal_written [256];
  int unsigned  written_list[$];

  int unsigned  send_gap, rx_hold, cycles;
  bit           tx_steady, rx_steady;
  int unsigned  failures, words_taken, pal_taken, texels_seen, settings_seen;

  clut_texel_to_rgba_converter_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] widen_chan(logic [4:0] v);
    int unsigned w;
    w = (int'(v) * 255) / 31;
    return w[7:0];
  endfunction

  function automatic clut_pkg::pixel_t rgba_of(logic [15:0] c, bit clear);
    return {clear ? 8'h00 : 8'hFF, widen_chan(c[14:10]), widen_chan(c[9:5]),
            widen_chan(c[4:0])};
  endfunction

  function automatic clut_pkg::pixel_t palette_rgba(int unsigned idx);
    logic [15:0] c;
    c = '0;
    if (!present_sh) return clut_pkg::OPAQUE_BLACK;
    if (idx < clut_pkg::PALETTE_DEPTH) c = palette_sh[idx];
    return rgba_of(c, idx == 0);
  endfunction

  // Works out the texels of an accepted item and queues them
  task automatic expand_item(logic [clut_pkg::S_TDATA_W-1:0] d, logic cmd);
    logic [7:0]  idx;
    logic [15:0] col, word;
    int unsigned n, top;
    texel_t      t;
    idx  = d[7:0];
    col  = d[23:8];
    word = d[39:24];
    n    = d[42:40];
    if (cmd == clut_pkg::CMD_PAL_WRITE) begin
      if (idx < clut_pkg::PALETTE_DEPTH) palette_sh[idx] = col;
      pal_taken++;
      return;
    end
    words_taken++;
    top = (depth_sh == clut_pkg::DEPTH_4BIT) ? 4 :
          (depth_sh == clut_pkg::DEPTH_8BIT) ? 2 : 1;
    if (n > top) n = top;
    for (int unsigned k = 0; k < n; k++) begin
      case (depth_sh)
        clut_pkg::DEPTH_4BIT:   t.rgba = palette_rgba((word >> (4 * k)) & 16'hF);
        clut_pkg::DEPTH_8BIT:   t.rgba = palette_rgba((word >> (8 * k)) & 16'hFF);
        clut_pkg::DEPTH_DIRECT: t.rgba = rgba_of(word, word == 16'h0000);
        default:                t.rgba = clut_pkg::OPAQUE_BLACK;
      endcase
      t.last = (k + 1 == n);
      texel_q.push_back(t);
    end
  endtask

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) expand_item(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          tex_item_t it;
          it = item_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {5'b0, it.count, it.word, it.pal_color, it.pal_idx};
          s_tuser  <= it.cmd;
          send_gap <= pick_gap(tx_steady);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid  <= 1'b0;
      depth_sh   = clut_pkg::DEPTH_DIRECT;
      present_sh = 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == clut_pkg::CFG_DEPTH_MODE)
          depth_sh = clut_pkg::depth_mode_t'(cfg_data);
        else
          present_sh = cfg_data[0];
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() > 0) begin
          cfg_write_t w;
          w = cfg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.sel;
          cfg_data  <= w.val;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        texels_seen++;
        if (texel_q.size() == 0) begin
          $error("unexpected texel: pixel_rgba %h, last_of_word %b", m_tdata, m_tlast);
          failures++;
        end else begin
          texel_t e;
          e = texel_q.pop_front();
          if (m_tdata !== e.rgba) begin
            $error("pixel_rgba: expected %h, got %h", e.rgba, m_tdata);
            failures++;
          end
          if (m_tlast !== e.last) begin
            $error("last_of_word: expected %b, got %b", e.last, m_tlast);
            failures++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold  <= rx_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_hold  <= pick_gap(rx_steady);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d texels outstanding", cycles, texel_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(logic [15:0] word, logic [2:0] count);
    tex_item_t it;
    it.cmd       = clut_pkg::CMD_CONVERT;
    it.pal_idx   = $urandom_range(0, 255);
    it.pal_color = $urandom_range(0, 65535);
    it.word      = word;
    it.count     = count;
    item_q.push_back(it);
  endtask

  task automatic push_palette(logic [7:0] idx, logic [15:0] color);
    tex_item_t it;
    it.cmd       = clut_pkg::CMD_PAL_WRITE;
    it.pal_idx   = idx;
    it.pal_color = color;
    it.word      = $urandom_range(0, 65535);
    it.count     = $urandom_range(0, 7);
    item_q.push_back(it);
    if (!pal_written[idx]) begin
      pal_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // Waits until nothing is queued or in flight, then lets a trailing palette write finish
  task automatic wait_idle();
    do @(negedge clk); while (item_q.size() > 0 || s_tvalid || texel_q.size() > 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_config(clut_pkg::depth_mode_t mode, logic present);
    cfg_write_t w;
    wait_idle();
    w.sel = clut_pkg::CFG_DEPTH_MODE;
    w.val = mode;
    cfg_q.push_back(w);
    w.sel = clut_pkg::CFG_PALETTE_PRESENT;
    w.val = {1'($urandom_range(0, 1)), present};  // upper bit is don't-care
    cfg_q.push_back(w);
    do @(negedge clk); while (cfg_q.size() > 0 || cfg_valid);
    settings_seen++;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [15:0] indexed_word(bit nibbles);
    logic [15:0] w;
    int unsigned n;
    for (int k = 0; k < 4; k++) begin
      do n = $urandom_range(0, 15); while (!pal_written[n]);
      w[4*k +: 4] = n[3:0];
    end
    if (!nibbles) begin
      w[7:0]  = written_list[$urandom_range(0, written_list.size() - 1)];
      w[15:8] = written_list[$urandom_range(0, written_list.size() - 1)];
    end
    return w;
  endfunction

  function automatic logic [2:0] pick_count();
    logic [2:0] odd [4] = '{3'd0, 3'd5, 3'd6, 3'd7};
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
    return odd[$urandom_range(0, 3)];
  endfunction

  initial begin
    clut_pkg::depth_mode_t modes [8] = '{
      clut_pkg::DEPTH_4BIT, clut_pkg::DEPTH_8BIT, clut_pkg::DEPTH_DIRECT,
      clut_pkg::DEPTH_NONE, clut_pkg::DEPTH_4BIT, clut_pkg::DEPTH_8BIT,
      clut_pkg::DEPTH_DIRECT, clut_pkg::DEPTH_NONE};
    int unsigned order [8];
    clut_pkg::depth_mode_t mode;
    int unsigned j, tmp;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Direct colour at reset settings: transparent zero, bit 15 alone, clamping, empty word
    push_word(16'h0000, 3'd1);
    push_word(16'h8000, 3'd1);
    push_word(16'h7FFF, 3'd4);
    push_word(16'hFFFF, 3'd7);
    push_word(16'h1234, 3'd0);
    push_word(16'h5A5A, 3'd1);
    // Entry zero holds a colour yet stays transparent; bit 15 is stored but unused
    push_palette(8'h00, 16'h7FFF);
    push_palette(8'h01, 16'hFFFF);
    push_palette(8'h0F, 16'h8000);
    push_palette(8'hFF, 16'h0000);

    set_config(clut_pkg::DEPTH_4BIT, 1'b1);
    push_word(16'hF10F, 3'd4);
    push_word(16'h0000, 3'd2);
    push_word(16'h1F01, 3'd7);
    push_word(16'h0F1F, 3'd0);
    push_word(16'h00F1, 3'd1);

    set_config(clut_pkg::DEPTH_8BIT, 1'b1);
    push_word(16'hFF00, 3'd2);
    push_word(16'h01FF, 3'd5);
    push_word(16'h0100, 3'd1);

    // No palette: indexed modes give opaque black
    set_config(clut_pkg::DEPTH_4BIT, 1'b0);
    push_word(16'hF10F, 3'd4);
    set_config(clut_pkg::DEPTH_8BIT, 1'b0);
    push_word(16'hFF01, 3'd3);

    set_config(clut_pkg::DEPTH_NONE, 1'b1);
    push_word(16'hABCD, 3'd4);
    push_word(16'h0000, 3'd0);

    // Random part: every setting once, in shuffled order
    foreach (order[i]) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[p]) begin
      mode = modes[order[p]];
      set_config(mode, order[p] < 4);
      repeat (25) begin
        if ($urandom_range(0, 99) < 30)
          push_palette(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) :
                       $urandom_range(0, 255), $urandom_range(0, 65535));
        else if (mode == clut_pkg::DEPTH_4BIT || mode == clut_pkg::DEPTH_8BIT)
          push_word(indexed_word(mode == clut_pkg::DEPTH_4BIT), pick_count());
        else
          push_word(($urandom_range(0, 15) == 0) ? 16'h0000 : $urandom_range(0, 65535),
                    pick_count());
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    $display("items: %0d source words and %0d palette writes; texels checked: %0d",
             words_taken, pal_taken, texels_seen);
    $display("register settings visited: %0d, covering all depth modes with and without palette",
             settings_seen);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule
